FILE: hw/rtl/epd_pkg.sv
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types, constants, microcode program and arithmetic helpers for the
// encoder position drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package epd_pkg;

    // default parameter values
    localparam int COUNT_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF  = 16;

    // datapath widths
    localparam int DATA_W = 32;
    localparam int MUL_W  = DATA_W + 1;
    localparam int ACC_W  = 2 * MUL_W;
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic signed [DATA_W-1:0] SETPOINT_RST   = 32'sd823132;
    localparam logic signed [DATA_W-1:0] GAIN_PROP_RST  = 32'sd65536;
    localparam logic signed [DATA_W-1:0] GAIN_INTEG_RST = 32'sd0;
    localparam logic signed [DATA_W-1:0] GAIN_DERIV_RST = 32'sd0;
    localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = -32'sd196608;
    localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = 32'sd196608;
    localparam logic [DATA_W-1:0]        POS_SCALE_RST  = 32'd26353590;

    // duty mapping: 255 - ceil(85/8 * min(|out|, 24))
    localparam logic [7:0] DUTY_IDLE = 8'd255;
    localparam int         DUTY_SAT  = 24;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_GAIN_PROP  = 3'd1,
        REG_GAIN_INTEG = 3'd2,
        REG_GAIN_DERIV = 3'd3,
        REG_LIMIT_LOW  = 3'd4,
        REG_LIMIT_HIGH = 3'd5,
        REG_AUTO_EN    = 3'd6,
        REG_POS_SCALE  = 3'd7
    } cfg_idx_t;

    // microcode fields
    typedef enum logic [1:0] {
        MA_COUNT, MA_GAIN_I, MA_GAIN_P, MA_GAIN_D
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_SCALE, MB_ERR, MB_DPOS
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_INTEG_PLUS, ACC_MINUS
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NONE, JMP_EDGE, JMP_MANUAL
    } jmp_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_DISPATCH = 4'd0;
    localparam step_t ST_MODE     = 4'd1;
    localparam step_t ST_SEED     = 4'd2;
    localparam step_t ST_POS      = 4'd3;
    localparam step_t ST_DIFF     = 4'd4;
    localparam step_t ST_MUL_I    = 4'd5;
    localparam step_t ST_ACC_I    = 4'd6;
    localparam step_t ST_INTEG    = 4'd7;
    localparam step_t ST_ACC_P    = 4'd8;
    localparam step_t ST_ACC_D    = 4'd9;
    localparam step_t ST_OUT      = 4'd10;
    localparam step_t ST_REPORT   = 4'd11;
    localparam step_t ST_COUNT    = 4'd12;

    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        logic    mul_en;
        acc_op_t acc_op;
        logic    seed;
        logic    pos_ld;
        logic    diff_ld;
        logic    integ_ld;
        logic    out_ld;
        logic    report;
        logic    count_step;
        jmp_t    jmp;
        step_t   target;
        logic    last;
    } ucw_t;

    localparam ucw_t UC_NOP = '{
        mul_a: MA_COUNT, mul_b: MB_SCALE, mul_en: 1'b0, acc_op: ACC_HOLD,
        seed: 1'b0, pos_ld: 1'b0, diff_ld: 1'b0, integ_ld: 1'b0,
        out_ld: 1'b0, report: 1'b0, count_step: 1'b0,
        jmp: JMP_NONE, target: ST_DISPATCH, last: 1'b0
    };

    // control store
    function automatic ucw_t ucode(input step_t step);
        ucw_t w;
        w = UC_NOP;
        unique case (step)
            ST_DISPATCH: begin
                w.jmp    = JMP_EDGE;
                w.target = ST_COUNT;
            end
            ST_MODE: begin
                w.jmp    = JMP_MANUAL;
                w.target = ST_REPORT;
            end
            ST_SEED: begin
                w.seed   = 1'b1;
                w.mul_en = 1'b1;
                w.mul_a  = MA_COUNT;
                w.mul_b  = MB_SCALE;
            end
            ST_POS:  w.pos_ld  = 1'b1;
            ST_DIFF: w.diff_ld = 1'b1;
            ST_MUL_I: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_GAIN_I;
                w.mul_b  = MB_ERR;
            end
            ST_ACC_I: w.acc_op = ACC_INTEG_PLUS;
            ST_INTEG: begin
                w.integ_ld = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_a    = MA_GAIN_P;
                w.mul_b    = MB_ERR;
            end
            ST_ACC_P: begin
                w.acc_op = ACC_INTEG_PLUS;
                w.mul_en = 1'b1;
                w.mul_a  = MA_GAIN_D;
                w.mul_b  = MB_DPOS;
            end
            ST_ACC_D: w.acc_op = ACC_MINUS;
            ST_OUT:   w.out_ld = 1'b1;
            ST_REPORT: begin
                w.report = 1'b1;
                w.last   = 1'b1;
            end
            ST_COUNT: begin
                w.count_step = 1'b1;
                w.last       = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

    // ordered clamp: above high wins, then below low
    function automatic logic signed [DATA_W-1:0] clamp_lim(
        input logic signed [ACC_W-1:0]  x,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [ACC_W-1:0] lo_x;
        logic signed [ACC_W-1:0] hi_x;
        lo_x = {{(ACC_W-DATA_W){lo[DATA_W-1]}}, lo};
        hi_x = {{(ACC_W-DATA_W){hi[DATA_W-1]}}, hi};
        if (x > hi_x) begin
            return hi;
        end else if (x < lo_x) begin
            return lo;
        end
        return x[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] d);
        if (d[DATA_W] != d[DATA_W-1]) begin
            return d[DATA_W] ? S32_MIN : S32_MAX;
        end
        return d[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/encoder_pid_position_drive.sv
// Tick with auto mode on: runs the full PID program and gives a result word.
// Tick with auto mode off: gives a result word with the held drive value.
// Encoder edge: steps the count, no result word. A new item is taken only when idle.
// Ticks run a microcode program around one shared multiplier.
// Reset (aresetn low at a clock edge) loads register defaults and clears sequencer, controller and valid state.
// ----------------------------------------------------------------------------
// encoder_pid_position_drive
// Encoder pulse counter and PID position loop with derivative on measurement,
// run by a small microcoded sequencer over a multiply-accumulate datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_pid_position_drive #(
    parameter int COUNT_BITS = epd_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = epd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [epd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [epd_pkg::DATA_W-1:0]         cfg_wr_data,
    // input words
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_action,
    input  wire logic                               s_channel_b,
    // result words
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [epd_pkg::DATA_W-1:0]       m_drive_value,
    output logic                                    m_drive_forward,
    output logic [7:0]                              m_duty_level,
    output logic signed [epd_pkg::DATA_W-1:0]       m_position_now
);

    localparam int DW        = epd_pkg::DATA_W;
    localparam int AW        = epd_pkg::ACC_W;
    localparam int MW        = epd_pkg::MUL_W;
    localparam int POS_SHIFT = DW - FRAC_BITS;
    localparam int DUTY_W    = FRAC_BITS + 12;
    localparam logic [DW-1:0] DUTY_CAP = DW'(epd_pkg::DUTY_SAT) << FRAC_BITS;
    localparam logic [DUTY_W-1:0] DUTY_RND = (DUTY_W'(1) << (FRAC_BITS + 3)) - DUTY_W'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    // configuration registers
    logic signed [DW-1:0] setpoint_reg, gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic signed [DW-1:0] limit_low_reg, limit_high_reg;
    logic                 auto_en_reg;
    logic [DW-1:0]        pos_scale_reg;

    // controller state
    logic [COUNT_BITS-1:0] count_reg;
    logic signed [DW-1:0]  pos_held_reg, pos_prev_reg, integ_reg, out_held_reg;
    logic                  was_auto_reg;

    // datapath temporaries
    logic signed [DW-1:0]  err_reg, dpos_reg;
    logic signed [AW-1:0]  prod_reg, acc_reg;
    logic                  action_reg, chb_reg;

    // sequencer
    logic                  busy_reg;
    epd_pkg::step_t        step_reg, step_next;
    epd_pkg::ucw_t         uc;
    logic                  stall, jump_taken, seq_done;

    // output register
    logic                  m_valid_reg;
    logic signed [DW-1:0]  m_drive_value_reg, m_position_now_reg;
    logic                  m_drive_forward_reg;
    logic [7:0]            m_duty_level_reg;

    logic                  in_acc;
    logic                  cfg_lim_wr;
    logic signed [DW-1:0]  lo_next, hi_next;

    assign s_ready = !busy_reg;
    assign in_acc  = s_valid && s_ready;

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    assign uc    = epd_pkg::ucode(step_reg);
    assign stall = uc.report && m_valid_reg && !m_ready;

    always_comb begin
        unique case (uc.jmp)
            epd_pkg::JMP_EDGE:   jump_taken = !action_reg;
            epd_pkg::JMP_MANUAL: jump_taken = !auto_en_reg;
            default:             jump_taken = 1'b0;
        endcase
        seq_done  = 1'b0;
        step_next = step_reg;
        if (!stall) begin
            if (jump_taken) begin
                step_next = uc.target;
            end else if (uc.last) begin
                seq_done  = 1'b1;
                step_next = epd_pkg::ST_DISPATCH;
            end else begin
                step_next = step_reg + epd_pkg::step_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= epd_pkg::ST_DISPATCH;
        end else if (in_acc) begin
            busy_reg <= 1'b1;
            step_reg <= epd_pkg::ST_DISPATCH;
        end else if (busy_reg) begin
            step_reg <= step_next;
            if (seq_done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            action_reg <= s_action;
            chb_reg    <= s_channel_b;
        end
    end

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [AW-1:0] fx, integ_x, pos_shift;
    logic signed [DW-1:0] pos_sat;
    logic                 active;

    assign active = busy_reg && !stall;

    always_comb begin
        unique case (uc.mul_a)
            epd_pkg::MA_COUNT:  mul_a = {{(MW-COUNT_BITS){1'b0}}, count_reg};
            epd_pkg::MA_GAIN_I: mul_a = {gain_integ_reg[DW-1], gain_integ_reg};
            epd_pkg::MA_GAIN_P: mul_a = {gain_prop_reg[DW-1], gain_prop_reg};
            default:            mul_a = {gain_deriv_reg[DW-1], gain_deriv_reg};
        endcase
        unique case (uc.mul_b)
            epd_pkg::MB_SCALE: mul_b = {1'b0, pos_scale_reg};
            epd_pkg::MB_ERR:   mul_b = {err_reg[DW-1], err_reg};
            default:           mul_b = {dpos_reg[DW-1], dpos_reg};
        endcase
    end

    // gain product back to Q16.16, floor rounding
    assign fx        = prod_reg >>> FRAC_BITS;
    assign integ_x   = {{(AW-DW){integ_reg[DW-1]}}, integ_reg};
    assign pos_shift = prod_reg >>> POS_SHIFT;
    assign pos_sat   = (|pos_shift[AW-1:DW-1]) ? epd_pkg::S32_MAX : pos_shift[DW-1:0];

    always_ff @(posedge aclk) begin
        if (active && uc.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (active) begin
            unique case (uc.acc_op)
                epd_pkg::ACC_INTEG_PLUS: acc_reg <= integ_x + fx;
                epd_pkg::ACC_MINUS:      acc_reg <= acc_reg - fx;
                default:                 acc_reg <= acc_reg;
            endcase
        end
        if (active && uc.diff_ld) begin
            err_reg  <= epd_pkg::sat32({setpoint_reg[DW-1], setpoint_reg}
                                       - {pos_held_reg[DW-1], pos_held_reg});
            dpos_reg <= epd_pkg::sat32({pos_held_reg[DW-1], pos_held_reg}
                                       - {pos_prev_reg[DW-1], pos_prev_reg});
        end
    end

    // ------------------------------------------------------------------------
    // configuration and controller state
    // ------------------------------------------------------------------------
    assign cfg_lim_wr = cfg_wr_en && (cfg_index == epd_pkg::REG_LIMIT_LOW ||
                                      cfg_index == epd_pkg::REG_LIMIT_HIGH);
    assign lo_next = (cfg_index == epd_pkg::REG_LIMIT_LOW)  ? cfg_wr_data : limit_low_reg;
    assign hi_next = (cfg_index == epd_pkg::REG_LIMIT_HIGH) ? cfg_wr_data : limit_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg   <= epd_pkg::SETPOINT_RST;
            gain_prop_reg  <= epd_pkg::GAIN_PROP_RST;
            gain_integ_reg <= epd_pkg::GAIN_INTEG_RST;
            gain_deriv_reg <= epd_pkg::GAIN_DERIV_RST;
            limit_low_reg  <= epd_pkg::LIMIT_LOW_RST;
            limit_high_reg <= epd_pkg::LIMIT_HIGH_RST;
            auto_en_reg    <= 1'b0;
            pos_scale_reg  <= epd_pkg::POS_SCALE_RST;
        end else if (cfg_wr_en) begin
            unique case (epd_pkg::cfg_idx_t'(cfg_index))
                epd_pkg::REG_SETPOINT:   setpoint_reg   <= cfg_wr_data;
                epd_pkg::REG_GAIN_PROP:  gain_prop_reg  <= cfg_wr_data;
                epd_pkg::REG_GAIN_INTEG: gain_integ_reg <= cfg_wr_data;
                epd_pkg::REG_GAIN_DERIV: gain_deriv_reg <= cfg_wr_data;
                epd_pkg::REG_LIMIT_LOW:  limit_low_reg  <= cfg_wr_data;
                epd_pkg::REG_LIMIT_HIGH: limit_high_reg <= cfg_wr_data;
                epd_pkg::REG_AUTO_EN:    auto_en_reg    <= cfg_wr_data[0];
                default:                 pos_scale_reg  <= cfg_wr_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            pos_held_reg <= '0;
            pos_prev_reg <= '0;
            integ_reg    <= '0;
            out_held_reg <= '0;
            was_auto_reg <= 1'b0;
        end else if (cfg_lim_wr) begin
            integ_reg    <= epd_pkg::clamp_lim(integ_x, lo_next, hi_next);
            out_held_reg <= epd_pkg::clamp_lim({{(AW-DW){out_held_reg[DW-1]}}, out_held_reg},
                                               lo_next, hi_next);
        end else if (cfg_wr_en && cfg_index == epd_pkg::REG_AUTO_EN && !cfg_wr_data[0]) begin
            was_auto_reg <= 1'b0;
        end else if (active) begin
            if (uc.count_step) begin
                if (chb_reg) begin
                    if (count_reg != COUNT_TOP) begin
                        count_reg <= count_reg + COUNT_BITS'(1);
                    end
                end else if (count_reg != '0) begin
                    count_reg <= count_reg - COUNT_BITS'(1);
                end
            end
            // first tick in auto mode picks up where manual mode left off
            if (uc.seed && !was_auto_reg) begin
                pos_prev_reg <= pos_held_reg;
                integ_reg    <= epd_pkg::clamp_lim(
                                    {{(AW-DW){out_held_reg[DW-1]}}, out_held_reg},
                                    limit_low_reg, limit_high_reg);
            end
            if (uc.pos_ld) begin
                pos_held_reg <= pos_sat;
            end
            if (uc.integ_ld) begin
                integ_reg <= epd_pkg::clamp_lim(acc_reg, limit_low_reg, limit_high_reg);
            end
            if (uc.out_ld) begin
                out_held_reg <= epd_pkg::clamp_lim(acc_reg, limit_low_reg, limit_high_reg);
                pos_prev_reg <= pos_held_reg;
            end
            if (uc.report) begin
                was_auto_reg <= auto_en_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result word: position, drive value, direction and inverted duty
    // ------------------------------------------------------------------------
    logic [DW:0]         mag_full;
    logic [DW-1:0]       mag, mag_cap;
    logic [DUTY_W-1:0]   cap_x, duty_sum;
    logic [7:0]          duty_up;

    assign mag_full = out_held_reg[DW-1] ? ((DW+1)'(0) - {out_held_reg[DW-1], out_held_reg})
                                         : {1'b0, out_held_reg};
    assign mag      = mag_full[DW-1:0];
    assign mag_cap  = (mag > DUTY_CAP) ? DUTY_CAP : mag;
    assign cap_x    = {{(DUTY_W-FRAC_BITS-5){1'b0}}, mag_cap[FRAC_BITS+4:0]};
    // times 85, plus rounding, over 8 << FRAC_BITS
    assign duty_sum = (cap_x << 6) + (cap_x << 4) + (cap_x << 2) + cap_x + DUTY_RND;
    assign duty_up  = duty_sum[FRAC_BITS+10:FRAC_BITS+3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (active && uc.report) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (active && uc.report) begin
            m_drive_value_reg   <= out_held_reg;
            m_drive_forward_reg <= !out_held_reg[DW-1];
            m_duty_level_reg    <= epd_pkg::DUTY_IDLE - duty_up;
            m_position_now_reg  <= pos_held_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_drive_value   = m_drive_value_reg;
    assign m_drive_forward = m_drive_forward_reg;
    assign m_duty_level    = m_duty_level_reg;
    assign m_position_now  = m_position_now_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/epd_checker.sv
// ----------------------------------------------------------------------------
// epd_checker
// Port-level checks for the encoder position drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

module epd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [epd_pkg::DATA_W-1:0]    m_drive_value,
    input wire logic                          m_drive_forward,
    input wire logic [7:0]                    m_duty_level,
    input wire logic [epd_pkg::DATA_W-1:0]    m_position_now
);

    // a stalled word stays valid and holds its drive value, duty level and position
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_value)
                                && $stable(m_duty_level) && $stable(m_position_now))
        else $error("result word changed while stalled");

    a_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_drive_forward == !m_drive_value[epd_pkg::DATA_W-1])
        else $error("direction does not match drive sign");

    a_duty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_value == '0 |-> m_duty_level == epd_pkg::DUTY_IDLE)
        else $error("zero drive with nonzero duty");

    a_duty_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_value != '0 |-> m_duty_level != epd_pkg::DUTY_IDLE)
        else $error("nonzero drive with idle duty");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind encoder_pid_position_drive epd_checker u_epd_checker (.*);

`default_nettype wire
